// File: rtl/egmp_pkg.sv
// egmp_pkg: shared types and constants for the energy guided max pool unit.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package egmp_pkg;

    // fixed field widths
    localparam int FLOW_W     = 14;
    localparam int ENERGY_W   = 16;
    localparam int POOLED_W   = 13;
    localparam int FACTOR_W   = 5;
    localparam int SIZE_W     = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;
    localparam int ROW_BITS   = 12;
    localparam int ROW_LIMIT  = 4096;

    // parameter defaults
    localparam int DEF_MAX_COLS    = 4096;
    localparam int DEF_MAX_FACTOR  = 16;
    localparam int DEF_ENERGY_BITS = 16;

    // output queue depth
    localparam int OUTQ_DEPTH = 4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_FACTOR = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_FACTOR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_COLS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS = 3'd3;

    // reset values
    localparam logic [FACTOR_W-1:0] RST_FACTOR = 5'd1;
    localparam logic [SIZE_W-1:0]   RST_SIZE   = 13'd4096;

    // per-pixel control from the scan counters
    typedef struct packed {
        logic in_block;    // pixel belongs to a full block
        logic first;       // first pixel of its block
        logic last;        // last pixel of its block
        logic row_done;    // block is the last full one of its output row
        logic frame_done;  // block is the last full one of the frame
    } t_pix_ctl;

    typedef struct packed {
        logic [POOLED_W-1:0] pooled_flow;
        logic                filled;
        logic                row_done;
        logic                frame_done;
    } t_result;

endpackage

`default_nettype wire

// File: rtl/egmp_scan.sv
// egmp_scan: raster position counters, block column address and block flags.
// Depends on egmp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module egmp_scan #(
    parameter int MAX_COLS   = egmp_pkg::DEF_MAX_COLS,
    parameter int MAX_FACTOR = egmp_pkg::DEF_MAX_FACTOR
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_restart,
    input  wire                                i_accept,
    input  wire  [egmp_pkg::FACTOR_W-1:0]      i_row_factor,
    input  wire  [egmp_pkg::FACTOR_W-1:0]      i_col_factor,
    input  wire  [egmp_pkg::SIZE_W-1:0]        i_image_cols,
    input  wire  [egmp_pkg::SIZE_W-1:0]        i_image_rows,
    output egmp_pkg::t_pix_ctl                 o_ctl,
    output logic [$clog2(MAX_COLS)-1:0]        o_addr
);

    localparam int CPW  = $clog2(MAX_COLS);
    localparam int FW   = $clog2(MAX_FACTOR + 1);
    localparam int CIBW = (MAX_FACTOR > 1) ? $clog2(MAX_FACTOR) : 1;
    localparam int RB   = egmp_pkg::ROW_BITS;
    localparam int SW   = ((CPW > FW) ? CPW : FW) + 2;
    localparam int RSW  = ((RB > FW) ? RB : FW) + 2;

    logic [FW-1:0]    rf_c, cf_c;
    logic [CPW:0]     cols_c;
    logic [RB:0]      rows_c;

    logic [CPW-1:0]   r_col_pos, n_col_pos;
    logic [RB-1:0]    r_row_pos, n_row_pos;
    logic [CIBW-1:0]  r_cib, n_cib;
    logic [CIBW-1:0]  r_rib, n_rib;
    logic [CPW-1:0]   r_bstart, n_bstart;   // column of the current block's start
    logic [CPW-1:0]   r_bcol, n_bcol;       // block column index
    logic [RB-1:0]    r_rstart, n_rstart;   // row of the current block row's start

    logic [SW-1:0]    bend, bend2;
    logic [RSW-1:0]   rend, rend2;
    logic             cib_last, rib_last, row_end, frame_end;

    // clamp configuration to the usable range
    always_comb begin
        if (i_row_factor == '0) begin
            rf_c = FW'(1);
        end else if (32'(i_row_factor) > MAX_FACTOR) begin
            rf_c = FW'(MAX_FACTOR);
        end else begin
            rf_c = FW'(i_row_factor);
        end
        if (i_col_factor == '0) begin
            cf_c = FW'(1);
        end else if (32'(i_col_factor) > MAX_FACTOR) begin
            cf_c = FW'(MAX_FACTOR);
        end else begin
            cf_c = FW'(i_col_factor);
        end
        if (i_image_cols == '0) begin
            cols_c = (CPW+1)'(1);
        end else if (32'(i_image_cols) > MAX_COLS) begin
            cols_c = (CPW+1)'(MAX_COLS);
        end else begin
            cols_c = (CPW+1)'(i_image_cols);
        end
        if (i_image_rows == '0) begin
            rows_c = (RB+1)'(1);
        end else if (32'(i_image_rows) > egmp_pkg::ROW_LIMIT) begin
            rows_c = (RB+1)'(egmp_pkg::ROW_LIMIT);
        end else begin
            rows_c = (RB+1)'(i_image_rows);
        end
    end

    // block extents: full if the block ends inside the image, last if the next does not
    assign bend  = SW'(r_bstart) + SW'(cf_c);
    assign bend2 = bend + SW'(cf_c);
    assign rend  = RSW'(r_rstart) + RSW'(rf_c);
    assign rend2 = rend + RSW'(rf_c);

    assign cib_last  = (FW'(r_cib) + FW'(1)) == cf_c;
    assign rib_last  = (FW'(r_rib) + FW'(1)) == rf_c;
    assign row_end   = ((CPW+1)'(r_col_pos) + (CPW+1)'(1)) >= cols_c;
    assign frame_end = ((RB+1)'(r_row_pos) + (RB+1)'(1)) >= rows_c;

    always_comb begin
        o_ctl.in_block   = (bend <= SW'(cols_c)) && (rend <= RSW'(rows_c));
        o_ctl.first      = (r_cib == '0) && (r_rib == '0);
        o_ctl.last       = cib_last && rib_last;
        o_ctl.row_done   = bend2 > SW'(cols_c);
        o_ctl.frame_done = (bend2 > SW'(cols_c)) && (rend2 > RSW'(rows_c));
        o_addr           = r_bcol;
    end

    always_comb begin
        n_col_pos = r_col_pos + CPW'(1);
        n_row_pos = r_row_pos;
        n_cib     = cib_last ? '0 : r_cib + CIBW'(1);
        n_rib     = r_rib;
        n_bstart  = cib_last ? r_bstart + CPW'(cf_c) : r_bstart;
        n_bcol    = cib_last ? r_bcol + CPW'(1) : r_bcol;
        n_rstart  = r_rstart;
        if (row_end) begin
            n_col_pos = '0;
            n_cib     = '0;
            n_bstart  = '0;
            n_bcol    = '0;
            n_rib     = rib_last ? '0 : r_rib + CIBW'(1);
            n_rstart  = rib_last ? r_rstart + RB'(rf_c) : r_rstart;
            n_row_pos = r_row_pos + RB'(1);
            if (frame_end) begin
                n_row_pos = '0;
                n_rib     = '0;
                n_rstart  = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_col_pos <= '0;
            r_row_pos <= '0;
            r_cib     <= '0;
            r_rib     <= '0;
            r_bstart  <= '0;
            r_bcol    <= '0;
            r_rstart  <= '0;
        end else if (i_accept) begin
            r_col_pos <= n_col_pos;
            r_row_pos <= n_row_pos;
            r_cib     <= n_cib;
            r_rib     <= n_rib;
            r_bstart  <= n_bstart;
            r_bcol    <= n_bcol;
            r_rstart  <= n_rstart;
        end
    end

endmodule

`default_nettype wire

// File: rtl/egmp_accum.sv
// egmp_accum: per block column accumulator memory with read-modify-write.
// Depends on egmp_pkg; fed by egmp_scan.
`timescale 1ns / 1ps
`default_nettype none

module egmp_accum #(
    parameter int MAX_COLS    = egmp_pkg::DEF_MAX_COLS,
    parameter int ENERGY_BITS = egmp_pkg::DEF_ENERGY_BITS
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_accept,
    input  egmp_pkg::t_pix_ctl                 i_ctl,
    input  wire  [$clog2(MAX_COLS)-1:0]        i_addr,
    input  wire  [egmp_pkg::FLOW_W-1:0]        i_flow,
    input  wire  [egmp_pkg::ENERGY_W-1:0]      i_energy,
    output logic                               o_busy,
    output logic                               o_push,
    output egmp_pkg::t_result                  o_result
);

    localparam int AW = $clog2(MAX_COLS);
    localparam int EW = (ENERGY_BITS < egmp_pkg::ENERGY_W) ? ENERGY_BITS : egmp_pkg::ENERGY_W;
    localparam int FL = egmp_pkg::FLOW_W;

    logic [EW-1:0] mem_energy [MAX_COLS];
    logic [FL-1:0] mem_flow   [MAX_COLS];

    // stage 1: pixel whose entry is being read
    logic                 r_s1_v;
    egmp_pkg::t_pix_ctl   r_s1_ctl;
    logic [AW-1:0]        r_s1_addr;
    logic [FL-1:0]        r_s1_flow;
    logic [EW-1:0]        r_s1_energy;
    logic [EW-1:0]        r_rd_energy;
    logic [FL-1:0]        r_rd_flow;

    // last write, covers a read issued in the same cycle as that write
    logic                 r_fw_v;
    logic [AW-1:0]        r_fw_addr;
    logic [EW-1:0]        r_fw_energy;
    logic [FL-1:0]        r_fw_flow;

    logic [EW-1:0]        old_energy, new_energy;
    logic [FL-1:0]        old_flow, new_flow;
    logic                 wr_en;

    always_comb begin
        if (r_s1_ctl.first) begin
            old_energy = '0;
            old_flow   = '0;
        end else if (r_fw_v && (r_fw_addr == r_s1_addr)) begin
            old_energy = r_fw_energy;
            old_flow   = r_fw_flow;
        end else begin
            old_energy = r_rd_energy;
            old_flow   = r_rd_flow;
        end
        // empty pixels carry a negative flow
        if (!r_s1_flow[FL-1] && (r_s1_energy > old_energy)) begin
            new_energy = r_s1_energy;
            new_flow   = r_s1_flow;
        end else begin
            new_energy = old_energy;
            new_flow   = old_flow;
        end
        wr_en = r_s1_v && r_s1_ctl.in_block;
    end

    always_comb begin
        o_busy                = r_s1_v;
        o_push                = wr_en && r_s1_ctl.last;
        o_result.filled       = new_energy != '0;
        o_result.pooled_flow  = (new_energy != '0) ? new_flow[egmp_pkg::POOLED_W-1:0] : '0;
        o_result.row_done     = r_s1_ctl.row_done;
        o_result.frame_done   = r_s1_ctl.frame_done;
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_rd_energy <= mem_energy[i_addr];
            r_rd_flow   <= mem_flow[i_addr];
        end
        if (wr_en) begin
            mem_energy[r_s1_addr] <= new_energy;
            mem_flow[r_s1_addr]   <= new_flow;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_fw_v <= 1'b0;
        end else begin
            r_s1_v <= i_accept;
            if (wr_en) begin
                r_fw_v <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_ctl    <= i_ctl;
            r_s1_addr   <= i_addr;
            r_s1_flow   <= i_flow;
            r_s1_energy <= i_energy[EW-1:0];
        end
        if (wr_en) begin
            r_fw_addr   <= r_s1_addr;
            r_fw_energy <= new_energy;
            r_fw_flow   <= new_flow;
        end
    end

endmodule

`default_nettype wire

// File: rtl/egmp_outq.sv
// egmp_outq: small result queue between the accumulator and the output port.
// Depends on egmp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module egmp_outq (
    input  wire                                       i_clk,
    input  wire                                       i_rst_n,
    input  wire                                       i_push,
    input  egmp_pkg::t_result                         i_data,
    input  wire                                       i_ready,
    output logic                                      o_valid,
    output egmp_pkg::t_result                         o_data,
    output logic [$clog2(egmp_pkg::OUTQ_DEPTH+1)-1:0] o_count
);

    localparam int PW = $clog2(egmp_pkg::OUTQ_DEPTH);
    localparam int CW = $clog2(egmp_pkg::OUTQ_DEPTH + 1);

    egmp_pkg::t_result r_q [egmp_pkg::OUTQ_DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          pop;

    assign pop     = (r_count != '0) && i_ready;
    assign o_valid = r_count != '0;
    assign o_data  = r_q[r_rd_ptr];
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PW'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
            case ({i_push, pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: rtl/energy_guided_max_pool_unit.sv
// energy_guided_max_pool_unit: top level, configuration registers and glue.
// Depends on egmp_pkg, egmp_scan, egmp_accum and egmp_outq.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+----------------------------------------------
//  pixel in | i_in_valid / o_in_ready    | i_flow_value, i_pixel_energy
//  block out| o_out_valid / i_out_ready  | o_pooled_flow, o_filled, o_row_done, o_frame_done
//  config   | i_cfg_we                   | i_cfg_index, i_cfg_data
//
// One pixel per cycle unless stalled; results pass the accumulator stage, then the queue.
// Rate is set by the accumulator memory's read-modify-write loop, closed by forwarding.
// Reset clears counters and queue, loads config defaults; accumulator memory is not cleared.
// Output stalls are absorbed by a four-entry result queue; input stalls before it overflows.
`timescale 1ns / 1ps
`default_nettype none

module energy_guided_max_pool_unit #(
    parameter int MAX_COLS    = egmp_pkg::DEF_MAX_COLS,
    parameter int MAX_FACTOR  = egmp_pkg::DEF_MAX_FACTOR,
    parameter int ENERGY_BITS = egmp_pkg::DEF_ENERGY_BITS
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_in_valid,
    output logic                                o_in_ready,
    input  wire  signed [egmp_pkg::FLOW_W-1:0]  i_flow_value,
    input  wire  [egmp_pkg::ENERGY_W-1:0]       i_pixel_energy,
    output logic                                o_out_valid,
    input  wire                                 i_out_ready,
    output logic [egmp_pkg::POOLED_W-1:0]       o_pooled_flow,
    output logic                                o_filled,
    output logic                                o_row_done,
    output logic                                o_frame_done,
    input  wire                                 i_cfg_we,
    input  wire  [egmp_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire  [egmp_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int AW = $clog2(MAX_COLS);
    localparam int QW = $clog2(egmp_pkg::OUTQ_DEPTH + 1);

    logic [egmp_pkg::FACTOR_W-1:0] r_row_factor, r_col_factor;
    logic [egmp_pkg::SIZE_W-1:0]   r_image_cols, r_image_rows;
    logic                          cfg_restart;

    logic                accept;
    egmp_pkg::t_pix_ctl  ctl;
    logic [AW-1:0]       addr;
    logic                busy;
    logic                push;
    egmp_pkg::t_result   result, out_data;
    logic [QW-1:0]       q_count;

    always_comb begin
        case (i_cfg_index)
            egmp_pkg::CFG_ROW_FACTOR,
            egmp_pkg::CFG_COL_FACTOR,
            egmp_pkg::CFG_IMAGE_COLS,
            egmp_pkg::CFG_IMAGE_ROWS: cfg_restart = i_cfg_we;
            default:                  cfg_restart = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_factor <= egmp_pkg::RST_FACTOR;
            r_col_factor <= egmp_pkg::RST_FACTOR;
            r_image_cols <= egmp_pkg::RST_SIZE;
            r_image_rows <= egmp_pkg::RST_SIZE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                egmp_pkg::CFG_ROW_FACTOR: r_row_factor <= i_cfg_data[egmp_pkg::FACTOR_W-1:0];
                egmp_pkg::CFG_COL_FACTOR: r_col_factor <= i_cfg_data[egmp_pkg::FACTOR_W-1:0];
                egmp_pkg::CFG_IMAGE_COLS: r_image_cols <= i_cfg_data;
                egmp_pkg::CFG_IMAGE_ROWS: r_image_rows <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // leave room in the queue for the pixel already in the accumulator stage
    assign o_in_ready = (QW+1)'(q_count) + (QW+1)'(busy) < (QW+1)'(egmp_pkg::OUTQ_DEPTH);
    assign accept     = i_in_valid && o_in_ready;

    egmp_scan #(
        .MAX_COLS   (MAX_COLS),
        .MAX_FACTOR (MAX_FACTOR)
    ) u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_restart    (cfg_restart),
        .i_accept     (accept),
        .i_row_factor (r_row_factor),
        .i_col_factor (r_col_factor),
        .i_image_cols (r_image_cols),
        .i_image_rows (r_image_rows),
        .o_ctl        (ctl),
        .o_addr       (addr)
    );

    egmp_accum #(
        .MAX_COLS    (MAX_COLS),
        .ENERGY_BITS (ENERGY_BITS)
    ) u_accum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_ctl    (ctl),
        .i_addr   (addr),
        .i_flow   (i_flow_value),
        .i_energy (i_pixel_energy),
        .o_busy   (busy),
        .o_push   (push),
        .o_result (result)
    );

    egmp_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (result),
        .i_ready (i_out_ready),
        .o_valid (o_out_valid),
        .o_data  (out_data),
        .o_count (q_count)
    );

    assign o_pooled_flow = out_data.pooled_flow;
    assign o_filled      = out_data.filled;
    assign o_row_done    = out_data.row_done;
    assign o_frame_done  = out_data.frame_done;

`ifndef NO_ASSERTIONS
    // a result is never pushed into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (q_count < QW'(egmp_pkg::OUTQ_DEPTH)))
        else $error("result queue overflow");

    // the accumulator stage holds only a pixel accepted in the previous cycle
    a_busy_follows_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> $past(accept))
        else $error("accumulator stage valid without an accepted pixel");

    // the frame's last block is also the last of its row
    a_frame_implies_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && result.frame_done |-> result.row_done)
        else $error("frame_done without row_done");

    // an empty block reports flow zero
    a_empty_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && !result.filled |-> (result.pooled_flow == '0))
        else $error("empty block with nonzero flow");
`endif

endmodule

`default_nettype wire
